### hdl/rlsi_pkg.sv
`default_nettype none

package rlsi_pkg;

  // Table depth and derived index widths
  localparam int unsigned MAX_RUNS = 512;
  localparam int unsigned ADDR_W   = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_RUNS + 1);

  localparam int unsigned DATA_W   = 32;

  // Request function codes
  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_CONSUME = 1'b1
  } func_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

### hdl/run_length_skip_iterator.sv
// Run-length skip iterator.
// Input channel (in_valid_i / in_stall_o) takes one request at a time:
// func_i = load appends the pair (run_length_i, run_symbol_i) to the run
// table; func_i = consume skips skip_count_i decoded elements from the
// current position. Every request yields exactly one result on the output
// channel (out_valid_o / out_stall_i): symbol_o and found_o for a consume,
// table_full_o for a load that found the table full.
// A load's result passes through the result registers into the output
// register; a consume's result does the same when the walk over the
// stored runs ends (it examines none when the position is already past
// the last run). The run table is a synchronous memory read once per
// cycle; the walk issues the read of the next run while it evaluates
// the current one, so one run is examined per cycle. The next request
// is accepted in the cycle after the result moves to the output register.
// Reset empties the table, rewinds the position to the first run and
// clears the output valid flag. While the receiver stalls, one finished
// result waits in the output register and one more waits inside; no
// further request is accepted until the output register frees up.
`default_nettype none

module run_length_skip_iterator (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire                  func_i,
  input  wire  [31:0]          run_length_i,
  input  wire  [31:0]          run_symbol_i,
  input  wire  [31:0]          skip_count_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [31:0]          symbol_o,
  output logic                 found_o,
  output logic                 table_full_o
);
  import rlsi_pkg::*;

  // Run table memories
  data_t len_mem [MAX_RUNS];
  data_t sym_mem [MAX_RUNS];

  state_e state_q, state_d;
  cnt_t   loaded_q, loaded_d;
  cnt_t   cur_q, cur_d;
  data_t  used_q, used_d;
  data_t  want_q, want_d;

  data_t  rd_len_q, rd_sym_q;
  addr_t  rd_addr;
  logic   wr_en;

  data_t  res_symbol_q, res_symbol_d;
  logic   res_found_q, res_found_d;
  logic   res_full_q, res_full_d;

  logic   out_valid_q, out_valid_d;
  data_t  symbol_q;
  logic   found_q, full_q;

  logic   in_acc;
  logic   table_full;
  cnt_t   cur_nxt;
  data_t  left;
  logic   covered;
  logic   out_free;
  logic   out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign table_full = (loaded_q >= cnt_t'(MAX_RUNS));
  assign cur_nxt    = cur_q + cnt_t'(1);
  assign left       = rd_len_q - used_q;
  assign covered    = !(left < want_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DONE) && out_free;
  assign wr_en      = in_acc && (func_i == FUNC_LOAD) && !table_full;

  // Read current run on accept, prefetch the next run while walking
  always_comb begin
    if (state_q == S_WALK) begin
      rd_addr = cur_nxt[ADDR_W-1:0];
    end else begin
      rd_addr = cur_q[ADDR_W-1:0];
    end
  end

  // Run table write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      len_mem[loaded_q[ADDR_W-1:0]] <= run_length_i;
      sym_mem[loaded_q[ADDR_W-1:0]] <= run_symbol_i;
    end
    rd_len_q <= len_mem[rd_addr];
    rd_sym_q <= sym_mem[rd_addr];
  end

  // Sequencer: accept, walk the runs, hand the result over
  always_comb begin
    state_d      = state_q;
    loaded_d     = loaded_q;
    cur_d        = cur_q;
    used_d       = used_q;
    want_d       = want_q;
    res_symbol_d = res_symbol_q;
    res_found_d  = res_found_q;
    res_full_d   = res_full_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_symbol_d = '0;
          res_found_d  = 1'b0;
          res_full_d   = 1'b0;
          if (func_i == FUNC_LOAD) begin
            res_full_d = table_full;
            if (!table_full) begin
              loaded_d = loaded_q + cnt_t'(1);
            end
            state_d = S_DONE;
          end else begin
            want_d = skip_count_i;
            if (cur_q < loaded_q) begin
              state_d = S_WALK;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_WALK: begin
        if (covered) begin
          used_d       = used_q + want_q;
          res_symbol_d = rd_sym_q;
          res_found_d  = 1'b1;
          state_d      = S_DONE;
        end else begin
          want_d = want_q - left;
          used_d = '0;
          cur_d  = cur_nxt;
          if (cur_nxt >= loaded_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loaded_q    <= '0;
      cur_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    want_q       <= want_d;
    res_symbol_q <= res_symbol_d;
    res_found_q  <= res_found_d;
    res_full_q   <= res_full_d;
    if (out_load) begin
      symbol_q <= res_symbol_q;
      found_q  <= res_found_q;
      full_q   <= res_full_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign symbol_o     = symbol_q;
  assign found_o      = found_q;
  assign table_full_o = full_q;

  // Position never runs past the loaded pairs
  a_cur_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= loaded_q)
    else $error("position beyond loaded pairs");

  // Table count stays within depth
  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= cnt_t'(MAX_RUNS))
    else $error("pair count beyond table depth");

  // Walk only visits stored runs
  a_walk_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cur_q < loaded_q))
    else $error("walk on unloaded run");

  // Exhausted position carries no partial use
  a_exhausted_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q == loaded_q) |-> (used_q == '0))
    else $error("used count nonzero past the last run");

  // A stored load grows the table by one
  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func_i == FUNC_LOAD) && !table_full)
      |=> (loaded_q == $past(loaded_q) + cnt_t'(1)))
    else $error("load did not advance pair count");

endmodule

`default_nettype wire
